// ===== src/kdp_pkg.sv =====
package kdp_pkg;

  localparam int MAX_ITEMS_DEF    = 64;
  localparam int MAX_CAPACITY_DEF = 1024;
  localparam int PROFIT_BITS_DEF  = 16;

  localparam int ID_W     = 6;
  localparam int WEIGHT_W = 11;
  localparam int PROFIT_W = 16;
  localparam int BEST_W   = 22;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [BEST_W-1:0]     BEST_MAX     = 22'h3FFFFF;
  localparam logic [CFG_DATA_W-1:0] CAPACITY_RST = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY  = 1'b0,
    REG_TAKE_TIES = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]     item_id;
    logic [WEIGHT_W-1:0] weight;
    logic [PROFIT_W-1:0] profit;
    logic                last_item;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_item_id;
    logic              chosen;
    logic [BEST_W-1:0] best_value;
    logic              last_result;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_BT_START,
    ST_BT_BEST,
    ST_BT_READ,
    ST_BT_EMIT
  } state_t;

endpackage

// ===== src/kdp_ram.sv =====
module kdp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/kdp_table.sv =====
module kdp_table #(
  parameter int W     = 23,
  parameter int DEPTH = 1025,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/kdp_relax.sv =====
module kdp_relax #(
  parameter int VAL_W = 23
) (
  input  logic [VAL_W-1:0] profit,
  input  logic [VAL_W-1:0] best_s,
  input  logic [VAL_W-1:0] best_sw,
  input  logic             in_range,
  input  logic             take_ties,
  output logic [VAL_W-1:0] cand,
  output logic             take
);

  assign cand = profit + best_sw;
  assign take = in_range && ((cand > best_s) || (take_ties && (cand == best_s)));

endmodule

// ===== src/knapsack01_dp_engine_core.sv =====
// 0/1 knapsack engine. Items are accepted one transaction at a time; each stored item
// sweeps the profit table from MAX_CAPACITY down to 0 with one read-modify-write of the
// table per cycle; an item passes through accept (ST_IDLE), the sweep and a drain state
// (ST_SWEEP_END) before the next is accepted. The transaction marked last_item then
// starts a backtrack from the configured capacity, clamped to MAX_CAPACITY: ST_BT_START
// and ST_BT_BEST fetch the optimum, then ST_BT_READ and ST_BT_EMIT run per stored item
// (ST_BT_EMIT waits while result_ready is low), one result per item in reverse order.
// After backtrack and reset, a clearing pass writes the table to zero; no item is taken.
// Configuration writes are always taken but must only be issued while the block is idle.
module knapsack01_dp_engine_core #(
  parameter int MAX_ITEMS    = kdp_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAPACITY = kdp_pkg::MAX_CAPACITY_DEF,
  parameter int PROFIT_BITS  = kdp_pkg::PROFIT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  kdp_pkg::item_t                  item_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output kdp_pkg::result_t                result_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kdp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CAP_W     = $clog2(MAX_CAPACITY + 1);
  localparam int CW        = (CAP_W > kdp_pkg::WEIGHT_W) ? CAP_W : kdp_pkg::WEIGHT_W;
  localparam int SLOT_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W     = PROFIT_BITS + $clog2(MAX_ITEMS) + 1;
  localparam int VAL_W     = (SUM_W > kdp_pkg::BEST_W) ? SUM_W : kdp_pkg::BEST_W;
  localparam int ROW       = MAX_CAPACITY + 1;
  localparam int DEC_DEPTH = MAX_ITEMS * ROW;
  localparam int DEC_AW    = $clog2(DEC_DEPTH);
  localparam int RB_W      = $clog2(DEC_DEPTH + 1);
  localparam int ITEM_W    = kdp_pkg::ID_W + kdp_pkg::WEIGHT_W;

  localparam logic [kdp_pkg::PROFIT_W-1:0] PMASK = (PROFIT_BITS >= kdp_pkg::PROFIT_W) ?
    {kdp_pkg::PROFIT_W{1'b1}} : kdp_pkg::PROFIT_W'((64'd1 << PROFIT_BITS) - 64'd1);
  localparam logic [CAP_W-1:0] MAXC     = CAP_W'(MAX_CAPACITY);
  localparam logic [CW-1:0]    MAXC_CW  = CW'(MAX_CAPACITY);
  localparam logic [RB_W-1:0]  ROW_RB   = RB_W'(ROW);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ITEMS);

  kdp_pkg::state_t state, state_next;

  logic [kdp_pkg::CFG_DATA_W-1:0] capacity;
  logic                           take_ties;

  logic [CAP_W-1:0]             s, s_next;
  logic                         p1_valid, p1_valid_next;
  logic [CAP_W-1:0]             p1_s, p1_s_next;
  logic                         p1_in, p1_in_next;
  logic [kdp_pkg::WEIGHT_W-1:0] cur_w, cur_w_next;
  logic [VAL_W-1:0]             cur_p, cur_p_next;
  logic                         last_flag, last_flag_next;
  logic [CNT_W-1:0]             item_count, item_count_next;
  logic [RB_W-1:0]              row_base, row_base_next;
  logic [CAP_W-1:0]             bt_c, bt_c_next;
  logic [CNT_W-1:0]             bt_k, bt_k_next;
  logic [kdp_pkg::BEST_W-1:0]   best_reg, best_reg_next;
  logic                         res_valid, res_valid_next;
  kdp_pkg::result_t             res, res_next;

  logic                 tbl_we;
  logic [CAP_W-1:0]     tbl_waddr, tbl_raddr_a, tbl_raddr_b;
  logic [VAL_W-1:0]     tbl_wdata, tbl_rdata_a, tbl_rdata_b;
  logic                 dec_we, dec_wdata, dec_rdata;
  logic [DEC_AW-1:0]    dec_waddr, dec_raddr;
  logic                 item_we;
  logic [ITEM_W-1:0]    item_wdata, item_rdata;
  logic [SLOT_W-1:0]    item_waddr, item_raddr;

  logic [VAL_W-1:0]             cand;
  logic                         take;
  logic                         in_range;
  logic [CAP_W-1:0]             s_minus_w;
  logic [CAP_W-1:0]             cap_eff;
  logic [kdp_pkg::WEIGHT_W-1:0] bt_w;
  logic                         bt_fits;
  logic                         emit_load;

  kdp_table #(.W(VAL_W), .DEPTH(ROW), .AW(CAP_W)) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr_a (tbl_raddr_a),
    .raddr_b (tbl_raddr_b),
    .rdata_a (tbl_rdata_a),
    .rdata_b (tbl_rdata_b)
  );

  kdp_ram #(.W(1), .DEPTH(DEC_DEPTH), .AW(DEC_AW)) u_dec_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (dec_waddr),
    .wdata (dec_wdata),
    .raddr (dec_raddr),
    .rdata (dec_rdata)
  );

  kdp_ram #(.W(ITEM_W), .DEPTH(MAX_ITEMS), .AW(SLOT_W)) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wdata),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  kdp_relax #(.VAL_W(VAL_W)) u_relax (
    .profit    (cur_p),
    .best_s    (tbl_rdata_a),
    .best_sw   (tbl_rdata_b),
    .in_range  (p1_in),
    .take_ties (take_ties),
    .cand      (cand),
    .take      (take)
  );

  assign in_range  = CW'(s) >= CW'(cur_w);
  assign s_minus_w = in_range ? CAP_W'(CW'(s) - CW'(cur_w)) : s;
  assign cap_eff   = (CW'(capacity) > MAXC_CW) ? MAXC : CAP_W'(capacity);
  assign bt_w      = item_rdata[kdp_pkg::WEIGHT_W-1:0];
  assign bt_fits   = CW'(bt_w) <= CW'(bt_c);
  assign emit_load = (state == kdp_pkg::ST_BT_EMIT) && (!res_valid || result_ready);

  assign item_ready   = (state == kdp_pkg::ST_IDLE);
  assign result_valid = res_valid;
  assign result_data  = res;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= kdp_pkg::CAPACITY_RST;
      take_ties <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        kdp_pkg::REG_CAPACITY:  capacity  <= cfg_data;
        kdp_pkg::REG_TAKE_TIES: take_ties <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kdp_pkg::ST_CLEAR;
      s          <= MAXC;
      p1_valid   <= 1'b0;
      item_count <= '0;
      row_base   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      s          <= s_next;
      p1_valid   <= p1_valid_next;
      item_count <= item_count_next;
      row_base   <= row_base_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p1_s      <= p1_s_next;
    p1_in     <= p1_in_next;
    cur_w     <= cur_w_next;
    cur_p     <= cur_p_next;
    last_flag <= last_flag_next;
    bt_c      <= bt_c_next;
    bt_k      <= bt_k_next;
    best_reg  <= best_reg_next;
    res       <= res_next;
  end

  always_comb begin
    state_next      = state;
    s_next          = s;
    p1_valid_next   = 1'b0;
    p1_s_next       = s;
    p1_in_next      = in_range;
    cur_w_next      = cur_w;
    cur_p_next      = cur_p;
    last_flag_next  = last_flag;
    item_count_next = item_count;
    row_base_next   = row_base;
    bt_c_next       = bt_c;
    bt_k_next       = bt_k;
    best_reg_next   = best_reg;
    res_valid_next  = res_valid && !result_ready;
    res_next        = res;

    tbl_we      = p1_valid && take;
    tbl_waddr   = p1_s;
    tbl_wdata   = cand;
    tbl_raddr_a = s;
    tbl_raddr_b = s_minus_w;
    dec_we      = p1_valid;
    dec_waddr   = DEC_AW'(row_base + RB_W'(p1_s));
    dec_wdata   = take;
    dec_raddr   = DEC_AW'(row_base + RB_W'(bt_c));
    item_we     = 1'b0;
    item_waddr  = item_count[SLOT_W-1:0];
    item_wdata  = {item_data.item_id, item_data.weight};
    item_raddr  = bt_k[SLOT_W-1:0];

    unique case (state)
      kdp_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = s;
        tbl_wdata = '0;
        if (s == '0) begin
          state_next      = kdp_pkg::ST_IDLE;
          item_count_next = '0;
          row_base_next   = '0;
        end else begin
          s_next = s - 1'b1;
        end
      end
      kdp_pkg::ST_IDLE: begin
        if (item_valid) begin
          cur_w_next     = item_data.weight;
          cur_p_next     = VAL_W'(item_data.profit & PMASK);
          last_flag_next = item_data.last_item;
          s_next         = MAXC;
          if (item_count < MAX_CNT) begin
            item_we    = 1'b1;
            state_next = kdp_pkg::ST_SWEEP;
          end else if (item_data.last_item) begin
            state_next = kdp_pkg::ST_BT_START;
          end
        end
      end
      kdp_pkg::ST_SWEEP: begin
        p1_valid_next = 1'b1;
        if (s == '0) begin
          state_next = kdp_pkg::ST_SWEEP_END;
        end else begin
          s_next = s - 1'b1;
        end
      end
      kdp_pkg::ST_SWEEP_END: begin
        item_count_next = item_count + 1'b1;
        row_base_next   = row_base + ROW_RB;
        state_next      = last_flag ? kdp_pkg::ST_BT_START : kdp_pkg::ST_IDLE;
      end
      kdp_pkg::ST_BT_START: begin
        tbl_raddr_a = cap_eff;
        bt_c_next   = cap_eff;
        bt_k_next   = item_count;
        state_next  = kdp_pkg::ST_BT_BEST;
      end
      kdp_pkg::ST_BT_BEST: begin
        best_reg_next = (tbl_rdata_a > VAL_W'(kdp_pkg::BEST_MAX)) ? kdp_pkg::BEST_MAX :
                        tbl_rdata_a[kdp_pkg::BEST_W-1:0];
        if (bt_k == '0) begin
          s_next     = MAXC;
          state_next = kdp_pkg::ST_CLEAR;
        end else begin
          bt_k_next     = bt_k - 1'b1;
          row_base_next = row_base - ROW_RB;
          state_next    = kdp_pkg::ST_BT_READ;
        end
      end
      kdp_pkg::ST_BT_READ: begin
        state_next = kdp_pkg::ST_BT_EMIT;
      end
      kdp_pkg::ST_BT_EMIT: begin
        if (emit_load) begin
          res_valid_next       = 1'b1;
          res_next.out_item_id = item_rdata[ITEM_W-1:kdp_pkg::WEIGHT_W];
          res_next.chosen      = dec_rdata;
          res_next.best_value  = best_reg;
          res_next.last_result = (bt_k == '0);
          if (dec_rdata && bt_fits) begin
            bt_c_next = CAP_W'(CW'(bt_c) - CW'(bt_w));
          end
          if (bt_k == '0) begin
            s_next     = MAXC;
            state_next = kdp_pkg::ST_CLEAR;
          end else begin
            bt_k_next     = bt_k - 1'b1;
            row_base_next = row_base - ROW_RB;
            state_next    = kdp_pkg::ST_BT_READ;
          end
        end
      end
      default: begin
        state_next = kdp_pkg::ST_CLEAR;
      end
    endcase
  end

  // sweep pipeline only carries work inside the sweep
  assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> (state == kdp_pkg::ST_SWEEP || state == kdp_pkg::ST_SWEEP_END))
    else $error("sweep write outside sweep");

  assert property (@(posedge clk) disable iff (rst)
    item_count <= MAX_CNT)
    else $error("item count overflow");

  // the final result of a run hands over to the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (emit_load && bt_k == '0) |=> (state == kdp_pkg::ST_CLEAR && res_valid && res.last_result))
    else $error("backtrack did not end in clear");

  // no new result is produced outside the backtrack
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> $past(state == kdp_pkg::ST_BT_EMIT))
    else $error("result outside backtrack");

  assert property (@(posedge clk) disable iff (rst)
    (state == kdp_pkg::ST_SWEEP && $past(state == kdp_pkg::ST_SWEEP)) |-> (s == $past(s) - 1'b1))
    else $error("sweep counter skipped");

endmodule
